// File: rtl/mei_pkg.sv
`default_nettype none
package mei_pkg;

	localparam int ZERO_SLOTS = 32;
	localparam int ADDR_W = $clog2(ZERO_SLOTS);
	localparam int TURN_W = $clog2(ZERO_SLOTS + 1);

	// shared divider: wide enough for the analysis sum and for the resolution
	localparam int DVD_W = 32 + $clog2(ZERO_SLOTS) + 1;
	localparam int DSR_W = 33;
	localparam int DCNT_W = $clog2(DVD_W);

	localparam int TENTH_DIV = 10;

	// configuration register indexes
	localparam logic [2:0] REG_LOCK_Q    = 3'd0;
	localparam logic [2:0] REG_VOLT_STEP = 3'd1;
	localparam logic [2:0] REG_VOLT_LIM  = 3'd2;
	localparam logic [2:0] REG_ANG_STEP  = 3'd3;
	localparam logic [2:0] REG_LOCK_TCK  = 3'd4;
	localparam logic [2:0] REG_DIR_WIN   = 3'd5;
	localparam logic [2:0] REG_DIR_PER   = 3'd6;
	localparam logic [2:0] REG_WRAP_JMP  = 3'd7;

	typedef enum logic [3:0] {
		PH_IDLE = 4'd0,
		PH_VOLT = 4'd1,
		PH_DIR  = 4'd2,
		PH_RES  = 4'd3,
		PH_RET  = 4'd4,
		PH_FWD  = 4'd5,
		PH_REV  = 4'd6,
		PH_ANA  = 4'd7,
		PH_DONE = 4'd8,
		PH_ERR  = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		ERR_NONE   = 2'd0,
		ERR_ENABLE = 2'd1,
		ERR_POLES  = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		DIR_UNKNOWN = 2'd0,
		DIR_SAME    = 2'd1,
		DIR_REV     = 2'd2
	} dir_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRE,
		ST_ANA_PER,
		ST_ANA_LOAD,
		ST_ANA_MOD,
		ST_ANA_AVG,
		ST_CHK,
		ST_DIV,
		ST_SWEEP,
		ST_OUT
	} seq_t;

endpackage
`default_nettype wire

// File: rtl/motor_encoder_identification.sv
`default_nettype none
// Servo commissioning sequencer. Each accepted word is one control tick; one result word
// comes back per tick. A tick inside the direction-sweep window adds one pass of the
// shared bit-serial divider. The analysis tick needs one divider pass for the period,
// then, if any zero positions were recorded, one load per recorded position (at most
// ZERO_SLOTS) plus a divider pass for each when the period is nonzero, and one pass
// for the mean. A stalled result word holds off the next tick. Configuration is to be
// written between ticks; the block itself does not enforce this.
module motor_encoder_identification (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_write,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [30:0]         cfg_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                enable,
	input  wire logic                axis_enabled,
	input  wire logic [31:0]         enc_position,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [15:0]              angle_ref,
	output logic signed [15:0]       ud_ref,
	output logic signed [15:0]       uq_ref,
	output logic                     drive_enable,
	output logic [3:0]               phase,
	output logic [1:0]               error_code,
	output logic [1:0]               direction,
	output logic [32:0]              resolution,
	output logic [31:0]              offset,
	output logic [5:0]               pole_pairs
);

	localparam int TW = mei_pkg::TURN_W;
	localparam int AW = mei_pkg::ADDR_W;

	// configuration
	logic        lock_q_q;
	logic [10:0] volt_step_q, dir_per_q;
	logic [14:0] volt_lim_q;
	logic [15:0] ang_step_q, lock_tck_q, dir_win_q;
	logic [30:0] wrap_jmp_q;

	// tick word
	logic        en_q, axis_q, rise_q, eff_q, prev_en_q;
	logic [31:0] pos_q;

	// run state
	mei_pkg::seq_t   st_q, st_d;
	mei_pkg::phase_t phase_q, ph_chk;
	mei_pkg::err_t   err_q;
	mei_pkg::dir_t   dir_q;
	logic [15:0] tick_q, inc_q, dec_q, hold_q, angle_q;
	logic [31:0] max_q, prev_q, fs_q, off_q;
	logic [TW-1:0] turn_q, rev_q, pp_q, n_q, idx_q;
	logic [15:0] ud_q, uq_q;
	logic [32:0] res_q, per_q;
	logic [mei_pkg::DVD_W-1:0] sum_q;

	// output register
	logic        ov_q;
	logic [15:0] o_angle_q, o_ud_q, o_uq_q;
	logic        o_eff_q;
	logic [3:0]  o_phase_q;
	logic [1:0]  o_err_q, o_dir_q;
	logic [32:0] o_res_q;
	logic [31:0] o_off_q;
	logic [5:0]  o_pp_q;

	// divider and memory
	logic                       div_start, div_done;
	logic [mei_pkg::DVD_W-1:0]  div_dvd, div_quot;
	logic [mei_pkg::DSR_W-1:0]  div_dsr, div_rem;
	logic                       rd_en, wr_en;
	logic [AW-1:0]              rd_addr;
	logic [31:0]                rd_data;

	logic        in_acc, out_free, chk_err, need_div;
	logic [15:0] tc1, hc1, ang_fwd, ang_back, per1;
	logic [TW-1:0] idx_n, turn1;
	logic        ana_adv, ana_last;
	logic [mei_pkg::DVD_W-1:0] sum_new;
	logic [32:0] term;

	mei_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dsr),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	mei_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (turn_q[AW-1:0]),
		.wr_data (pos_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	function automatic logic [31:0] smear(input logic [31:0] m);
		logic [31:0] r;
		r = m;
		r = r | (r >> 1);
		r = r | (r >> 2);
		r = r | (r >> 4);
		r = r | (r >> 8);
		r = r | (r >> 16);
		return r;
	endfunction

	assign in_stall = (st_q != mei_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !ov_q || !out_stall;

	assign tc1      = tick_q + 16'd1;
	assign hc1      = hold_q + 16'd1;
	assign ang_fwd  = angle_q + ang_step_q;
	assign ang_back = angle_q - ang_step_q;
	assign per1     = (dir_per_q == 11'd0) ? 16'd1 : {5'd0, dir_per_q};
	assign turn1    = turn_q + 1'b1;

	// analysis walk
	assign idx_n    = idx_q + 1'b1;
	assign ana_last = (idx_n == n_q);
	assign term     = (per_q != 33'd0) ? div_rem : {1'b0, rd_data};
	assign sum_new  = sum_q + mei_pkg::DVD_W'(term);
	assign ana_adv  = (st_q == mei_pkg::ST_ANA_LOAD && per_q == 33'd0) ||
		(st_q == mei_pkg::ST_ANA_MOD && div_done);

	// enable check
	always_comb begin
		ph_chk  = phase_q;
		chk_err = 1'b0;
		case (phase_q)
			mei_pkg::PH_DONE, mei_pkg::PH_ERR: begin
				if (rise_q) ph_chk = mei_pkg::PH_IDLE;
			end
			mei_pkg::PH_IDLE: ;
			default: begin
				if (!en_q) begin
					ph_chk  = mei_pkg::PH_ERR;
					chk_err = 1'b1;
				end
			end
		endcase
	end

	// sequencer next state, divider and memory control
	always_comb begin
		st_d      = st_q;
		div_start = 1'b0;
		div_dvd   = '0;
		div_dsr   = '0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		need_div  = 1'b0;
		unique case (st_q)
			mei_pkg::ST_IDLE: begin
				if (in_acc) st_d = mei_pkg::ST_PRE;
			end
			mei_pkg::ST_PRE: begin
				if (phase_q == mei_pkg::PH_ANA) begin
					div_start = 1'b1;
					div_dvd   = mei_pkg::DVD_W'(res_q);
					div_dsr   = mei_pkg::DSR_W'(pp_q);
					st_d      = mei_pkg::ST_ANA_PER;
				end else begin
					st_d = mei_pkg::ST_CHK;
				end
			end
			mei_pkg::ST_ANA_PER: begin
				if (div_done) begin
					if (turn_q == '0) begin
						st_d = mei_pkg::ST_CHK;
					end else begin
						rd_en = 1'b1;
						st_d  = mei_pkg::ST_ANA_LOAD;
					end
				end
			end
			mei_pkg::ST_ANA_LOAD, mei_pkg::ST_ANA_MOD: begin
				if (st_q == mei_pkg::ST_ANA_LOAD && per_q != 33'd0) begin
					div_start = 1'b1;
					div_dvd   = mei_pkg::DVD_W'(rd_data);
					div_dsr   = per_q;
					st_d      = mei_pkg::ST_ANA_MOD;
				end else if (ana_adv) begin
					if (ana_last) begin
						div_start = 1'b1;
						div_dvd   = sum_new;
						div_dsr   = mei_pkg::DSR_W'(n_q);
						st_d      = mei_pkg::ST_ANA_AVG;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_n[AW-1:0];
						st_d    = mei_pkg::ST_ANA_LOAD;
					end
				end
			end
			mei_pkg::ST_ANA_AVG: begin
				if (div_done) st_d = mei_pkg::ST_CHK;
			end
			mei_pkg::ST_CHK: begin
				if (ph_chk == mei_pkg::PH_DIR && tc1 < dir_win_q) begin
					need_div = 1'b1;
					div_dvd  = mei_pkg::DVD_W'(tc1);
					div_dsr  = mei_pkg::DSR_W'(per1);
				end
				div_start = need_div;
				st_d      = need_div ? mei_pkg::ST_DIV : mei_pkg::ST_SWEEP;
			end
			mei_pkg::ST_DIV: begin
				if (div_done) st_d = mei_pkg::ST_SWEEP;
			end
			mei_pkg::ST_SWEEP: begin
				st_d = mei_pkg::ST_OUT;
			end
			mei_pkg::ST_OUT: begin
				if (out_free) st_d = mei_pkg::ST_IDLE;
			end
			default: st_d = mei_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= mei_pkg::ST_IDLE;
		else st_q <= st_d;
	end

	// memory write only in the sweep of a counted turn
	always_comb begin
		wr_en = 1'b0;
		if (st_q == mei_pkg::ST_SWEEP && angle_q == 16'd0 && hc1 == lock_tck_q) begin
			if (phase_q == mei_pkg::PH_FWD && turn_q < TW'(mei_pkg::ZERO_SLOTS)) wr_en = 1'b1;
			if (phase_q == mei_pkg::PH_REV) wr_en = 1'b1;
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q_q    <= 1'b0;
			volt_step_q <= 11'd4;
			volt_lim_q  <= 15'd5000;
			ang_step_q  <= 16'd64;
			lock_tck_q  <= 16'd1600;
			dir_win_q   <= 16'd1000;
			dir_per_q   <= 11'd20;
			wrap_jmp_q  <= 31'd1000;
		end else if (cfg_write) begin
			unique case (cfg_index)
				mei_pkg::REG_LOCK_Q:    lock_q_q    <= cfg_data[0];
				mei_pkg::REG_VOLT_STEP: volt_step_q <= cfg_data[10:0];
				mei_pkg::REG_VOLT_LIM:  volt_lim_q  <= cfg_data[14:0];
				mei_pkg::REG_ANG_STEP:  ang_step_q  <= cfg_data[15:0];
				mei_pkg::REG_LOCK_TCK:  lock_tck_q  <= cfg_data[15:0];
				mei_pkg::REG_DIR_WIN:   dir_win_q   <= cfg_data[15:0];
				mei_pkg::REG_DIR_PER:   dir_per_q   <= cfg_data[10:0];
				mei_pkg::REG_WRAP_JMP:  wrap_jmp_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sweep helpers
	logic [15:0] vsel, vnew;
	logic [16:0] vsum;
	logic [31:0] dpos, mx, ad;
	logic        wrap_hit, near;
	logic [32:0] tenth;

	always_comb begin
		vsel     = lock_q_q ? uq_q : ud_q;
		vsum     = {1'b0, vsel} + 17'(volt_step_q);
		vnew     = (vsum > 17'd32767) ? 16'h7FFF : vsum[15:0];
		dpos     = (dir_q == mei_pkg::DIR_SAME) ? (prev_q - pos_q) : (pos_q - prev_q);
		mx       = (max_q < pos_q) ? pos_q : max_q;
		wrap_hit = !dpos[31] && (dpos > {1'b0, wrap_jmp_q});
		ad       = (pos_q > fs_q) ? (pos_q - fs_q) : (fs_q - pos_q);
		// resolution is zero or a power of two, so a tenth of it is a constant per bit
		tenth    = '0;
		for (int i = 0; i < 33; i++) begin
			if (res_q[i]) tenth = tenth | 33'((64'd1 << i) / mei_pkg::TENTH_DIV);
		end
		near     = (tenth > {1'b0, ad}) ||
			(({1'b0, ad} <= res_q) && (tenth > (res_q - {1'b0, ad})));
	end

	// tick datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0; axis_q <= 1'b0; rise_q <= 1'b0; eff_q <= 1'b0;
			prev_en_q <= 1'b0; pos_q <= '0;
			phase_q <= mei_pkg::PH_IDLE; err_q <= mei_pkg::ERR_NONE;
			dir_q <= mei_pkg::DIR_UNKNOWN;
			tick_q <= '0; inc_q <= '0; dec_q <= '0; hold_q <= '0; angle_q <= '0;
			max_q <= '0; prev_q <= '0; fs_q <= '0; off_q <= '0;
			turn_q <= '0; rev_q <= '0; pp_q <= '0; n_q <= '0; idx_q <= '0;
			ud_q <= '0; uq_q <= '0; res_q <= '0; per_q <= '0; sum_q <= '0;
		end else begin
			case (st_q)
				mei_pkg::ST_IDLE: begin
					if (in_acc) begin
						en_q      <= enable;
						axis_q    <= axis_enabled;
						pos_q     <= enc_position;
						rise_q    <= enable && !prev_en_q;
						eff_q     <= (phase_q == mei_pkg::PH_DONE || phase_q == mei_pkg::PH_ERR)
							? (enable && !prev_en_q) : enable;
						prev_en_q <= enable;
					end
				end
				mei_pkg::ST_PRE: begin
					if (phase_q == mei_pkg::PH_IDLE && eff_q && axis_q) begin
						tick_q <= '0; inc_q <= '0; dec_q <= '0; hold_q <= '0;
						max_q <= '0; prev_q <= '0; fs_q <= '0; off_q <= '0;
						turn_q <= '0; rev_q <= '0; pp_q <= '0;
						dir_q <= mei_pkg::DIR_UNKNOWN; res_q <= '0;
						err_q <= mei_pkg::ERR_NONE;
						angle_q <= '0; ud_q <= '0; uq_q <= '0;
						phase_q <= mei_pkg::PH_VOLT;
					end
				end
				mei_pkg::ST_ANA_PER: begin
					if (div_done) begin
						per_q <= div_quot[32:0];
						n_q   <= (turn_q > TW'(mei_pkg::ZERO_SLOTS))
							? TW'(mei_pkg::ZERO_SLOTS) : turn_q;
						idx_q <= '0;
						sum_q <= '0;
						if (turn_q == '0) begin
							off_q   <= '0;
							phase_q <= mei_pkg::PH_DONE;
						end
					end
				end
				mei_pkg::ST_ANA_LOAD, mei_pkg::ST_ANA_MOD: begin
					if (ana_adv) begin
						sum_q <= sum_new;
						idx_q <= idx_n;
					end
				end
				mei_pkg::ST_ANA_AVG: begin
					if (div_done) begin
						off_q   <= div_quot[31:0];
						phase_q <= mei_pkg::PH_DONE;
					end
				end
				mei_pkg::ST_CHK: begin
					phase_q <= ph_chk;
					if (chk_err) err_q <= mei_pkg::ERR_ENABLE;
				end
				mei_pkg::ST_SWEEP: begin
					case (phase_q)
						mei_pkg::PH_VOLT: begin
							angle_q <= '0;
							if (lock_q_q) begin
								uq_q <= vnew; ud_q <= '0;
							end else begin
								ud_q <= vnew; uq_q <= '0;
							end
							if (vnew > {1'b0, volt_lim_q}) phase_q <= mei_pkg::PH_DIR;
						end
						mei_pkg::PH_DIR: begin
							tick_q <= tc1;
							if (tc1 < dir_win_q) begin
								// remainder of the sample counter
								if (div_rem == '0) begin
									if (pos_q > prev_q) begin
										if (inc_q != 16'hFFFF) inc_q <= inc_q + 16'd1;
									end else if (pos_q < prev_q) begin
										if (dec_q != 16'hFFFF) dec_q <= dec_q + 16'd1;
									end
									prev_q <= pos_q;
								end
								angle_q <= ang_fwd;
							end else begin
								dir_q   <= (inc_q > dec_q) ? mei_pkg::DIR_SAME : mei_pkg::DIR_REV;
								prev_q  <= pos_q;
								phase_q <= mei_pkg::PH_RES;
							end
						end
						mei_pkg::PH_RES: begin
							if (wrap_hit) begin
								max_q   <= '0;
								res_q   <= {1'b0, smear(mx)} + 33'd1;
								phase_q <= mei_pkg::PH_RET;
							end else begin
								max_q   <= mx;
								prev_q  <= pos_q;
								angle_q <= ang_fwd;
							end
						end
						mei_pkg::PH_RET: begin
							if (angle_q == 16'd0) begin
								if (hc1 == lock_tck_q) begin
									hold_q  <= '0;
									fs_q    <= pos_q;
									angle_q <= ang_fwd;
									phase_q <= mei_pkg::PH_FWD;
								end else begin
									hold_q <= hc1;
								end
							end else begin
								angle_q <= ang_fwd;
							end
						end
						mei_pkg::PH_FWD: begin
							if (angle_q == 16'd0) begin
								if (hc1 == lock_tck_q) begin
									hold_q <= '0;
									if (turn_q >= TW'(mei_pkg::ZERO_SLOTS)) begin
										phase_q <= mei_pkg::PH_ERR;
										err_q   <= mei_pkg::ERR_POLES;
									end else begin
										turn_q <= turn1;
										if (near) begin
											pp_q <= turn1;
											if (turn1 > TW'(mei_pkg::ZERO_SLOTS / 2)) begin
												phase_q <= mei_pkg::PH_ANA;
											end else begin
												rev_q   <= turn1;
												angle_q <= ang_back;
												phase_q <= mei_pkg::PH_REV;
											end
										end else begin
											angle_q <= ang_fwd;
										end
									end
								end else begin
									hold_q <= hc1;
								end
							end else begin
								angle_q <= ang_fwd;
							end
						end
						mei_pkg::PH_REV: begin
							if (angle_q == 16'd0) begin
								if (hc1 == lock_tck_q) begin
									hold_q <= '0;
									turn_q <= turn1;
									if (rev_q <= TW'(1)) begin
										rev_q   <= '0;
										phase_q <= mei_pkg::PH_ANA;
									end else begin
										rev_q   <= rev_q - 1'b1;
										angle_q <= ang_back;
									end
								end else begin
									hold_q <= hc1;
								end
							end else begin
								angle_q <= ang_back;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			o_angle_q <= '0; o_ud_q <= '0; o_uq_q <= '0; o_eff_q <= 1'b0;
			o_phase_q <= '0; o_err_q <= '0; o_dir_q <= '0;
			o_res_q <= '0; o_off_q <= '0; o_pp_q <= '0;
		end else if (st_q == mei_pkg::ST_OUT && out_free) begin
			ov_q      <= 1'b1;
			o_angle_q <= angle_q;
			o_ud_q    <= ud_q;
			o_uq_q    <= uq_q;
			o_eff_q   <= eff_q;
			o_phase_q <= phase_q;
			o_err_q   <= err_q;
			o_dir_q   <= dir_q;
			o_res_q   <= res_q;
			o_off_q   <= off_q;
			o_pp_q    <= 6'(pp_q);
		end else if (ov_q && !out_stall) begin
			ov_q <= 1'b0;
		end
	end

	assign out_valid    = ov_q;
	assign angle_ref    = o_angle_q;
	assign ud_ref       = o_ud_q;
	assign uq_ref       = o_uq_q;
	assign drive_enable = o_eff_q;
	assign phase        = o_phase_q;
	assign error_code   = o_err_q;
	assign direction    = o_dir_q;
	assign resolution   = o_res_q;
	assign offset       = o_off_q;
	assign pole_pairs   = o_pp_q;

endmodule
`default_nettype wire

// File: rtl/mei_div.sv
`default_nettype none
module mei_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [mei_pkg::DVD_W-1:0]    dividend,
	input  wire logic [mei_pkg::DSR_W-1:0]    divisor,
	output logic                              done,
	output logic [mei_pkg::DVD_W-1:0]         quotient,
	output logic [mei_pkg::DSR_W-1:0]         remainder
);

	logic                          busy_q, done_q;
	logic [mei_pkg::DCNT_W-1:0]    cnt_q;
	logic [mei_pkg::DVD_W-1:0]     quo_q;
	logic [mei_pkg::DSR_W:0]       rem_q;
	logic [mei_pkg::DSR_W-1:0]     dsr_q;
	logic [mei_pkg::DSR_W:0]       trial, diff;
	logic                          ge;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q[mei_pkg::DSR_W-1:0], quo_q[mei_pkg::DVD_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
		end else if (start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			dsr_q  <= divisor;
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			quo_q <= {quo_q[mei_pkg::DVD_W-2:0], ge};
			rem_q <= ge ? diff : trial;
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == mei_pkg::DCNT_W'(mei_pkg::DVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q[mei_pkg::DSR_W-1:0];

endmodule
`default_nettype wire

// File: rtl/mei_ram.sv
`default_nettype none
module mei_ram (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic [mei_pkg::ADDR_W-1:0]  wr_addr,
	input  wire logic [31:0]                 wr_data,
	input  wire logic                        rd_en,
	input  wire logic [mei_pkg::ADDR_W-1:0]  rd_addr,
	output logic [31:0]                      rd_data
);

	logic [31:0] mem [mei_pkg::ZERO_SLOTS];
	logic [31:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule
`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;

	typedef struct packed {
		logic [15:0] angle;
		logic [15:0] ud;
		logic [15:0] uq;
		logic        drive;
		logic [3:0]  ph;
		logic [1:0]  ec;
		logic [1:0]  dir;
		logic [32:0] resol;
		logic [31:0] offs;
		logic [5:0]  pp;
	} tick_out_t;

	typedef struct {
		bit                  en;
		bit                  ax;
		bit [31:0]           pos;
		bit                  typed;
		mei_pkg::phase_t     ph;
		mei_pkg::err_t       ec;
	} tick_row_t;

	logic clk, arst_n;
	logic cfg_write;
	logic [2:0] cfg_index;
	logic [30:0] cfg_data;
	logic in_valid, in_stall, enable, axis_enabled;
	logic [31:0] enc_position;
	logic out_valid, out_stall;
	logic [15:0] angle_ref;
	logic signed [15:0] ud_ref, uq_ref;
	logic drive_enable;
	logic [3:0] phase;
	logic [1:0] error_code, direction;
	logic [32:0] resolution;
	logic [31:0] offset;
	logic [5:0] pole_pairs;

	motor_encoder_identification uut (.*);

	// commissioning settings as last written
	int unsigned c_lockq, c_vstep, c_vlim, c_astep, c_lock, c_dwin, c_dper, c_wrap;

	// sequencer state as the block should hold it
	mei_pkg::phase_t seq_ph;
	mei_pkg::err_t seq_err;
	mei_pkg::dir_t seq_dir;
	bit en_prev;
	bit [15:0] tick_cnt, up_votes, down_votes, hold_cnt, ang;
	bit [31:0] pos_max, pos_prev, fwd_origin, offs_res;
	int turns, rev_left, pp_res, ud_v, uq_v;
	bit [31:0] zero_pos [mei_pkg::ZERO_SLOTS];
	longint unsigned res_v;

	tick_out_t expected_q[$];
	int fails, items, runs_done, runs_err, idle_cycles;
	bit hold_req;

	// simulated motor: unwrapped electrical angle mapped onto encoder counts
	longint mot_e, mot_r, mot_off, mot_sgn, mot_p;

	function automatic bit hold_tick();
		hold_cnt = hold_cnt + 16'd1;
		if (hold_cnt == c_lock[15:0]) begin
			hold_cnt = 0;
			return 1;
		end
		return 0;
	endfunction

	function automatic tick_out_t predict_tick(bit en, bit axis, bit [31:0] pos);
		tick_out_t o;
		bit rise, eff;
		int x, n, bits, per_s;
		bit [31:0] d, m;
		longint unsigned per, sum, ad, tenth;
		rise = en && !en_prev;
		eff = (seq_ph == mei_pkg::PH_DONE || seq_ph == mei_pkg::PH_ERR) ? rise : en;
		if (seq_ph == mei_pkg::PH_IDLE) begin
			if (eff && axis) begin
				tick_cnt = 0; up_votes = 0; down_votes = 0;
				pos_max = 0; pos_prev = 0; hold_cnt = 0; fwd_origin = 0;
				turns = 0; rev_left = 0;
				foreach (zero_pos[i]) zero_pos[i] = 0;
				seq_dir = mei_pkg::DIR_UNKNOWN; res_v = 0; offs_res = 0; pp_res = 0;
				seq_err = mei_pkg::ERR_NONE; ang = 0; ud_v = 0; uq_v = 0;
				seq_ph = mei_pkg::PH_VOLT;
			end
		end else if (seq_ph == mei_pkg::PH_ANA) begin
			per = pp_res ? res_v / pp_res : 0;
			sum = 0;
			n = turns > mei_pkg::ZERO_SLOTS ? mei_pkg::ZERO_SLOTS : turns;
			for (int i = 0; i < n; i++)
				sum += per ? longint'(zero_pos[i]) % per : longint'(zero_pos[i]);
			offs_res = n ? 32'(sum / n) : 0;
			seq_ph = mei_pkg::PH_DONE;
		end
		if (seq_ph == mei_pkg::PH_DONE || seq_ph == mei_pkg::PH_ERR) begin
			if (rise) seq_ph = mei_pkg::PH_IDLE;
		end else if (seq_ph != mei_pkg::PH_IDLE && !en) begin
			seq_ph = mei_pkg::PH_ERR;
			seq_err = mei_pkg::ERR_ENABLE;
		end
		case (seq_ph)
			mei_pkg::PH_VOLT: begin
				ang = 0;
				x = (c_lockq ? uq_v : ud_v) + int'(c_vstep);
				if (x > 32767) x = 32767;
				if (c_lockq) begin
					uq_v = x; ud_v = 0;
				end else begin
					ud_v = x; uq_v = 0;
				end
				if (x > int'(c_vlim)) seq_ph = mei_pkg::PH_DIR;
			end
			mei_pkg::PH_DIR: begin
				tick_cnt = tick_cnt + 16'd1;
				if (tick_cnt < c_dwin) begin
					per_s = c_dper ? c_dper : 1;
					if (tick_cnt % per_s == 0) begin
						if (pos > pos_prev) begin
							if (up_votes != 16'hFFFF) up_votes++;
						end else if (pos < pos_prev) begin
							if (down_votes != 16'hFFFF) down_votes++;
						end
						pos_prev = pos;
					end
					ang = ang + c_astep[15:0];
				end else begin
					seq_dir = up_votes > down_votes ? mei_pkg::DIR_SAME : mei_pkg::DIR_REV;
					pos_prev = pos;
					seq_ph = mei_pkg::PH_RES;
				end
			end
			mei_pkg::PH_RES: begin
				d = seq_dir == mei_pkg::DIR_SAME ? pos_prev - pos : pos - pos_prev;
				if (pos_max < pos) pos_max = pos;
				if (d <= 32'h7FFFFFFF && d > c_wrap) begin
					bits = 0;
					m = pos_max;
					while (m != 0) begin
						m = m >> 1;
						bits++;
					end
					pos_max = 0;
					res_v = 64'd1 << bits;
					seq_ph = mei_pkg::PH_RET;
				end else begin
					pos_prev = pos;
					ang = ang + c_astep[15:0];
				end
			end
			mei_pkg::PH_RET: begin
				if (ang == 0) begin
					if (hold_tick()) begin
						fwd_origin = pos;
						ang = ang + c_astep[15:0];
						seq_ph = mei_pkg::PH_FWD;
					end
				end else ang = ang + c_astep[15:0];
			end
			mei_pkg::PH_FWD: begin
				if (ang == 0) begin
					if (hold_tick()) begin
						if (turns >= mei_pkg::ZERO_SLOTS) begin
							seq_ph = mei_pkg::PH_ERR;
							seq_err = mei_pkg::ERR_POLES;
						end else begin
							zero_pos[turns % mei_pkg::ZERO_SLOTS] = pos;
							turns++;
							ad = pos > fwd_origin ? pos - fwd_origin : fwd_origin - pos;
							tenth = res_v / 10;
							if (tenth > ad || (ad <= res_v && tenth > res_v - ad)) begin
								pp_res = turns;
								if (pp_res > mei_pkg::ZERO_SLOTS / 2) seq_ph = mei_pkg::PH_ANA;
								else begin
									rev_left = turns;
									ang = ang - c_astep[15:0];
									seq_ph = mei_pkg::PH_REV;
								end
							end else ang = ang + c_astep[15:0];
						end
					end
				end else ang = ang + c_astep[15:0];
			end
			mei_pkg::PH_REV: begin
				if (ang == 0) begin
					if (hold_tick()) begin
						zero_pos[turns % mei_pkg::ZERO_SLOTS] = pos;
						turns++;
						if (rev_left) rev_left--;
						if (rev_left == 0) seq_ph = mei_pkg::PH_ANA;
						else ang = ang - c_astep[15:0];
					end
				end else ang = ang - c_astep[15:0];
			end
			default: ;
		endcase
		en_prev = en;
		o.angle = ang;
		o.ud = ud_v[15:0];
		o.uq = uq_v[15:0];
		o.drive = eff;
		o.ph = seq_ph;
		o.ec = seq_err;
		o.dir = seq_dir;
		o.resol = res_v[32:0];
		o.offs = offs_res;
		o.pp = pp_res[5:0];
		return o;
	endfunction

	function automatic bit [31:0] motor_pos();
		longint m;
		m = (mot_e * mot_r) / (mot_p * 65536);
		m = (mot_off + mot_sgn * m) % mot_r;
		if (m < 0) m += mot_r;
		return m[31:0];
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 40000) begin
			$display("%0t: no word moved for %0d cycles", $time, idle_cycles);
			$display("tb: failure");
			$finish;
		end
	end

	// result side: check, then choose the next stall
	initial begin : result_side
		tick_out_t got, want;
		int mode, hold_left, cyc;
		mode = 0; hold_left = 0; cyc = 0;
		out_stall <= 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (out_valid && !out_stall) begin
				got = {angle_ref, ud_ref, uq_ref, drive_enable, phase, error_code,
					direction, resolution, offset, pole_pairs};
				if (expected_q.size() == 0) begin
					$display("%0t: result word with nothing expected: %p", $time, got);
					fails++;
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected %p actual %p", $time, want, got);
						fails++;
					end
				end
			end
			if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 3);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1;
			end else if (hold_req) begin
				hold_req = 0;
				hold_left = 400;
				out_stall <= 1;
			end else case (mode)
				0: out_stall <= 0;
				1: out_stall <= $urandom_range(0, 99) < 30;
				2: out_stall <= (cyc % 5) < 2;
				default: out_stall <= $urandom_range(0, 99) < 80;
			endcase
		end
	end

	int burst_left;

	task automatic send_word(bit en, bit ax, bit [31:0] pos, bit typed = 0,
			mei_pkg::phase_t tph = mei_pkg::PH_IDLE, mei_pkg::err_t tec = mei_pkg::ERR_NONE);
		tick_out_t exp_out;
		bit [15:0] a0;
		logic signed [15:0] dlt;
		int gap;
		in_valid <= 1;
		enable <= en;
		axis_enabled <= ax;
		enc_position <= pos;
		do @(posedge clk); while (in_stall);
		a0 = ang;
		exp_out = predict_tick(en, ax, pos);
		dlt = ang - a0;
		mot_e += dlt;
		if (typed) begin
			exp_out.ph = tph;
			exp_out.ec = tec;
		end
		expected_q.push_back(exp_out);
		items++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain_results();
		in_valid <= 0;
		while (expected_q.size() != 0) @(posedge clk);
		// analysis ticks can still be in flight after the last word
		repeat (2000) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, int unsigned val);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= val[30:0];
		@(posedge clk);
		cfg_write <= 0;
		case (idx)
			mei_pkg::REG_LOCK_Q:    c_lockq = val & 1;
			mei_pkg::REG_VOLT_STEP: c_vstep = val & 32'h7FF;
			mei_pkg::REG_VOLT_LIM:  c_vlim = val & 32'h7FFF;
			mei_pkg::REG_ANG_STEP:  c_astep = val & 32'hFFFF;
			mei_pkg::REG_LOCK_TCK:  c_lock = val & 32'hFFFF;
			mei_pkg::REG_DIR_WIN:   c_dwin = val & 32'hFFFF;
			mei_pkg::REG_DIR_PER:   c_dper = val & 32'h7FF;
			default:                c_wrap = val & 32'h7FFFFFFF;
		endcase
	endtask

	task automatic write_all(int unsigned lq, vs, vl, as, lt, dw, dp, wj);
		write_reg(mei_pkg::REG_LOCK_Q, lq);
		write_reg(mei_pkg::REG_VOLT_STEP, vs);
		write_reg(mei_pkg::REG_VOLT_LIM, vl);
		write_reg(mei_pkg::REG_ANG_STEP, as);
		write_reg(mei_pkg::REG_LOCK_TCK, lt);
		write_reg(mei_pkg::REG_DIR_WIN, dw);
		write_reg(mei_pkg::REG_DIR_PER, dp);
		write_reg(mei_pkg::REG_WRAP_JMP, wj);
	endtask

	task automatic noise_words(int n);
		for (int i = 0; i < n; i++)
			send_word($urandom_range(0, 9) != 0, $urandom_range(0, 4) != 0, $urandom);
		send_word(0, $urandom_range(0, 1), $urandom);
		send_word(0, $urandom_range(0, 1), $urandom);
	endtask

	// one commissioning attempt against the simulated motor
	task automatic commission_run();
		bit [31:0] pos;
		bit en;
		if (c_astep >= 16384 && $urandom_range(0, 11) == 0) mot_p = $urandom_range(17, 40);
		else mot_p = $urandom_range(1, 6);
		mot_off = longint'({$urandom}) % mot_r;
		mot_sgn = $urandom_range(0, 1) ? 1 : -1;
		mot_e = 0;
		for (int n = 0; n < 900; n++) begin
			pos = motor_pos();
			if ($urandom_range(0, 49) == 0) pos = $urandom;
			en = $urandom_range(0, 299) != 0;
			send_word(en, 1, pos);
			if (seq_ph == mei_pkg::PH_DONE) begin
				runs_done++;
				break;
			end
			if (seq_ph == mei_pkg::PH_ERR) begin
				runs_err++;
				break;
			end
		end
		send_word(0, $urandom_range(0, 1), $urandom);
	endtask

	tick_row_t rows[12] = '{
		'{0, 0, 32'h0000_0000, 1, mei_pkg::PH_IDLE, mei_pkg::ERR_NONE},
		'{1, 0, 32'h0000_0000, 1, mei_pkg::PH_IDLE, mei_pkg::ERR_NONE},
		'{1, 1, 32'h0000_0000, 1, mei_pkg::PH_VOLT, mei_pkg::ERR_NONE},
		'{1, 1, 32'hFFFF_FFFF, 1, mei_pkg::PH_VOLT, mei_pkg::ERR_NONE},
		'{0, 1, 32'hFFFF_FFFF, 1, mei_pkg::PH_ERR, mei_pkg::ERR_ENABLE},
		'{0, 0, 32'h0000_0000, 1, mei_pkg::PH_ERR, mei_pkg::ERR_ENABLE},
		'{1, 0, 32'hAAAA_AAAA, 1, mei_pkg::PH_IDLE, mei_pkg::ERR_ENABLE},
		'{1, 1, 32'h5555_5555, 1, mei_pkg::PH_VOLT, mei_pkg::ERR_NONE},
		'{1, 1, 32'h8000_0000, 0, mei_pkg::PH_IDLE, mei_pkg::ERR_NONE},
		'{0, 1, 32'h7FFF_FFFF, 1, mei_pkg::PH_ERR, mei_pkg::ERR_ENABLE},
		'{1, 1, 32'h0000_0001, 1, mei_pkg::PH_IDLE, mei_pkg::ERR_ENABLE},
		'{0, 1, 32'hFFFF_FFFE, 1, mei_pkg::PH_IDLE, mei_pkg::ERR_ENABLE}
	};

	initial begin : stimulus
		int k;
		int unsigned wj;
		in_valid <= 0; enable <= 0; axis_enabled <= 0; enc_position <= 0;
		cfg_write <= 0; cfg_index <= mei_pkg::REG_LOCK_Q; cfg_data <= 0;
		c_lockq = 0; c_vstep = 4; c_vlim = 5000; c_astep = 64;
		c_lock = 1600; c_dwin = 1000; c_dper = 20; c_wrap = 1000;
		seq_ph = mei_pkg::PH_IDLE; seq_err = mei_pkg::ERR_NONE; seq_dir = mei_pkg::DIR_UNKNOWN;
		en_prev = 0; tick_cnt = 0; up_votes = 0; down_votes = 0; hold_cnt = 0; ang = 0;
		pos_max = 0; pos_prev = 0; fwd_origin = 0; offs_res = 0;
		turns = 0; rev_left = 0; pp_res = 0; ud_v = 0; uq_v = 0; res_v = 0;
		fails = 0; items = 0; runs_done = 0; runs_err = 0; idle_cycles = 0; hold_req = 0;
		mot_e = 0; mot_r = 1024; mot_off = 0; mot_sgn = 1; mot_p = 1;
		burst_left = 5;
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (rows[i])
			send_word(rows[i].en, rows[i].ax, rows[i].pos, rows[i].typed,
				rows[i].ph, rows[i].ec);

		k = 0;
		while (items < 1600) begin
			drain_results();
			if (k == 0) begin
				// ramp saturates at the limit and never leaves the voltage phase
				write_all(1, 1024, 32767, 32768, 65535, 65535, 1024, 32'h7FFFFFFF);
				noise_words(40);
			end else if (k == 1) begin
				write_all(0, 1, 1, 1, 1, 1, 1, 1);
				noise_words(40);
			end else begin
				mot_r = 64'd1 << $urandom_range(10, 32);
				wj = mot_r / 4 > 64'h7FFFFFFF ? 32'h7FFFFFFF : 32'(mot_r / 4);
				write_all($urandom_range(0, 1), $urandom_range(1, 1024),
					$urandom_range(1, 3000),
					32'd4096 << $urandom_range(0, 3), $urandom_range(1, 4),
					$urandom_range(2, 30),
					$urandom_range(0, 7) == 0 ? $urandom_range(1, 1024) : $urandom_range(1, 5),
					wj);
				if (c_vlim > c_vstep * 12) write_reg(mei_pkg::REG_VOLT_LIM, c_vstep * 12);
				for (int r = 0; r < 3; r++) begin
					if (items >= 1600) break;
					if (k == 2 && r == 1) hold_req = 1;
					commission_run();
				end
				if (k % 3 == 0) noise_words(15);
			end
			k++;
		end
		in_valid <= 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		if (expected_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_q.size());
			fails++;
		end
		$display("covered %0d ticks over %0d settings: %0d runs finished, %0d ended in error",
			items, k, runs_done, runs_err);
		if (fails == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule

// File: sim.f
rtl/mei_pkg.sv
rtl/mei_div.sv
rtl/mei_ram.sv
rtl/motor_encoder_identification.sv
bench/testbench.sv
